// File: src/safe_stop_release_supervisor_top_assert.svh
// Assertion macros for the safe stop release supervisor.
`ifndef SAFE_STOP_RELEASE_SUPERVISOR_TOP_ASSERT_SVH
`define SAFE_STOP_RELEASE_SUPERVISOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SSSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSSR_ASSERT_NEVER(lbl, cond, msg) \
    `SSSR_ASSERT(lbl, !(cond), msg)
`else
`define SSSR_ASSERT(lbl, prop, msg)
`define SSSR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: src/sssr_pkg.sv
// Shared types, codes and the modulo step of the safe stop release supervisor.
package sssr_pkg;

    localparam int POS_W      = 20;
    localparam int SEQ_W      = 32;
    localparam int SPD_W      = 16;
    localparam int LIM_W      = 15;
    localparam int MARGIN_W   = 16;
    localparam int CONF_W     = 8;
    localparam int STREAK_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int BIT_IDX_W  = $clog2(POS_W);

    localparam logic [1:0] OP_ACTIVATE = 2'd0;
    localparam logic [1:0] OP_RESET    = 2'd1;
    localparam logic [1:0] OP_EVAL     = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    localparam logic [1:0] WHY_NONE   = 2'd0;
    localparam logic [1:0] WHY_PASSED = 2'd1;
    localparam logic [1:0] WHY_AVOID  = 2'd2;
    localparam logic [1:0] WHY_CLEAR  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_MARGIN  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_LIMIT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM      = 8'd3;

    typedef struct packed {
        logic [1:0]              op;
        logic [POS_W-1:0]        position;
        logic [POS_W-1:0]        danger_end;
        logic signed [SPD_W-1:0] speed;
        logic [SEQ_W-1:0]        frame_seq;
        logic                    avoid_valid;
        logic                    frame_empty;
        logic                    corridor_clear;
        logic                    can_select_avoid;
    } sssr_req_t;

    typedef struct packed {
        logic                latched;
        logic                release_ok;
        logic [1:0]          release_why;
        logic                handoff_ok;
        logic                passed_flag;
        logic                stopped_flag;
        logic                cond_b;
        logic                cond_c;
        logic [STREAK_W-1:0] avoid_streak_out;
        logic [STREAK_W-1:0] clear_streak_out;
    } sssr_res_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } sssr_cfg_wr_t;

    typedef struct packed {
        logic [POS_W-1:0]    track_length;
        logic [MARGIN_W-1:0] pass_margin;
        logic [LIM_W-1:0]    stopped_speed_limit;
        logic [CONF_W-1:0]   confirm_cycles;
    } sssr_cfg_t;

    typedef struct packed {
        sssr_req_t        req;
        logic [POS_W-1:0] rem;
    } sssr_stage_t;

    typedef struct packed {
        logic             load;
        logic [POS_W-1:0] value;
    } sssr_mod_load_t;

    function automatic logic [POS_W-1:0] mod_step(input logic [POS_W-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [POS_W-1:0] len);
        logic [POS_W:0] partial;
        logic [POS_W:0] diff;
        partial = {rem, bit_in};
        diff    = partial - {1'b0, len};
        if (partial >= {1'b0, len})
        begin
            mod_step = diff[POS_W-1:0];
        end
        else
        begin
            mod_step = partial[POS_W-1:0];
        end
    endfunction

endpackage

// File: src/sssr_if.sv
// Request, result and configuration channel interfaces.
interface sssr_req_if import sssr_pkg::*; ();
    logic      valid;
    logic      ready;
    sssr_req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sssr_res_if import sssr_pkg::*; ();
    logic      valid;
    logic      ready;
    sssr_res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sssr_cfg_if import sssr_pkg::*; ();
    logic         valid;
    logic         ready;
    sssr_cfg_wr_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/safe_stop_release_supervisor_top.sv
// Top level of the safe stop release supervisor.
//
// Channels: req takes one request per handshake (activate, reset, evaluate);
// res returns one result for each evaluate request and none for the others;
// cfg writes a configuration register by index, always ready.
// A request accepted at a clock edge passes through the 20-stage position
// reduction pipeline and then updates the latch state, and its result is
// shown in the output register from then on.
// Throughput: one request per cycle unless a held result stalls an evaluate
// request; it is set by the pipeline that reduces the position modulo the
// lap length one bit per stage. A lap length write re-reduces the stored
// start position one bit a cycle, which ends before a request accepted
// after the write reaches the decision stage.
// Reset clears the latch, streaks and sequence marks, sets the confirm count
// to one and the other configuration registers to zero; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register while
// the pipeline keeps taking requests until its stages fill.
module safe_stop_release_supervisor_top import sssr_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    sssr_req_if.sink  req,
    sssr_res_if.source res,
    sssr_cfg_if.sink  cfg
);

    sssr_cfg_t        cfg_val;
    logic             len_wr;
    logic             pipe_valid;
    logic             pipe_ready;
    sssr_stage_t      pipe_item;
    logic [POS_W-1:0] start_mod;
    logic [POS_W-1:0] start_pos;
    sssr_mod_load_t   start_load;

    sssr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val),
        .len_wr  (len_wr)
    );

    sssr_mod_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_item   (req.data),
        .len       (cfg_val.track_length),
        .out_valid (pipe_valid),
        .out_ready (pipe_ready),
        .out_item  (pipe_item)
    );

    sssr_remod u_remod (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (start_load),
        .raw       (start_pos),
        .len_wr    (len_wr),
        .len       (cfg_val.track_length),
        .start_mod (start_mod)
    );

    sssr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pipe_valid),
        .in_ready   (pipe_ready),
        .in_item    (pipe_item),
        .cfg        (cfg_val),
        .start_mod  (start_mod),
        .start_pos  (start_pos),
        .start_load (start_load),
        .res        (res)
    );

endmodule

// File: src/sssr_cfg_regs.sv
// Configuration register file.
module sssr_cfg_regs import sssr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    sssr_cfg_if.sink  cfg,
    output sssr_cfg_t cfg_out,
    output logic      len_wr
);

    sssr_cfg_t cfg_reg;
    logic      wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid;
    assign len_wr    = wr && (cfg.data.index == CFG_TRACK_LENGTH);
    assign cfg_out   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.track_length        <= '0;
            cfg_reg.pass_margin         <= '0;
            cfg_reg.stopped_speed_limit <= '0;
            cfg_reg.confirm_cycles      <= CONF_W'(1);
        end
        else if (wr)
        begin
            unique case (cfg.data.index)
                CFG_TRACK_LENGTH: cfg_reg.track_length <= cfg.data.value[POS_W-1:0];
                CFG_PASS_MARGIN:  cfg_reg.pass_margin <= cfg.data.value[MARGIN_W-1:0];
                CFG_STOP_LIMIT:   cfg_reg.stopped_speed_limit <= cfg.data.value[LIM_W-1:0];
                CFG_CONFIRM:      cfg_reg.confirm_cycles <= cfg.data.value[CONF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: src/sssr_mod_pipe.sv
// Position reduction pipeline: one remainder bit per stage.
module sssr_mod_pipe import sssr_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sssr_req_t        in_item,
    input  logic [POS_W-1:0] len,
    output logic             out_valid,
    input  logic             out_ready,
    output sssr_stage_t      out_item
);

    localparam int NUM_STAGES = POS_W;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] take;
    sssr_stage_t           item_reg [NUM_STAGES];

    genvar k;
    generate
        for (k = 0; k < NUM_STAGES; k++)
        begin : g_stage
            sssr_stage_t src;
            sssr_stage_t stage_next;
            logic        src_vld;
            logic        down_rdy;

            if (k == 0)
            begin : g_first
                assign src_vld = in_valid;
                assign src     = '{req: in_item, rem: '0};
            end
            else
            begin : g_rest
                assign src_vld = vld_reg[k-1];
                assign src     = item_reg[k-1];
            end

            if (k == NUM_STAGES - 1)
            begin : g_last
                assign down_rdy = out_ready;
            end
            else
            begin : g_mid
                assign down_rdy = take[k+1];
            end

            assign take[k] = !vld_reg[k] || down_rdy;

            always_comb
            begin
                stage_next     = src;
                stage_next.rem = mod_step(src.rem, src.req.position[POS_W-1-k], len);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (take[k])
                begin
                    vld_reg[k] <= src_vld;
                end
            end

            always_ff @(posedge clk)
            begin
                if (take[k] && src_vld)
                begin
                    item_reg[k] <= stage_next;
                end
            end
        end
    endgenerate

    assign in_ready  = take[0];
    assign out_valid = vld_reg[NUM_STAGES-1];
    assign out_item  = item_reg[NUM_STAGES-1];

endmodule

// File: src/sssr_remod.sv
// Start position remainder, reloaded on activate and re-reduced after a lap length write.
module sssr_remod import sssr_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  sssr_mod_load_t   load,
    input  logic [POS_W-1:0] raw,
    input  logic             len_wr,
    input  logic [POS_W-1:0] len,
    output logic [POS_W-1:0] start_mod
);

    logic                 busy_reg;
    logic [BIT_IDX_W-1:0] cnt_reg;
    logic [POS_W-1:0]     rem_reg;
    logic [POS_W-1:0]     start_mod_reg;
    logic [POS_W-1:0]     rem_next;

    assign rem_next  = mod_step(rem_reg, raw[cnt_reg], len);
    assign start_mod = start_mod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            start_mod_reg <= '0;
        end
        else
        begin
            if (len_wr)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= BIT_IDX_W'(POS_W - 1);
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end

            priority if (load.load)
            begin
                start_mod_reg <= load.value;
            end
            else if (busy_reg && !len_wr && (cnt_reg == '0))
            begin
                start_mod_reg <= rem_next;
            end
        end
    end

endmodule

// File: src/sssr_core.sv
// Latch state, release decision and result register.
`include "safe_stop_release_supervisor_top_assert.svh"
module sssr_core import sssr_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sssr_stage_t      in_item,
    input  sssr_cfg_t        cfg,
    input  logic [POS_W-1:0] start_mod,
    output logic [POS_W-1:0] start_pos,
    output sssr_mod_load_t   start_load,
    sssr_res_if.source       res
);

    logic                latch_reg;
    logic [POS_W-1:0]    start_pos_reg;
    logic [POS_W-1:0]    danger_reg;
    logic [SEQ_W-1:0]    start_seq_reg;
    logic [STREAK_W-1:0] avoid_streak_reg;
    logic [STREAK_W-1:0] clear_streak_reg;
    logic [SEQ_W-1:0]    last_seq_reg;
    logic                out_valid_reg;
    sssr_res_t           out_reg;

    logic [STREAK_W-1:0] avoid_streak_next;
    logic [STREAK_W-1:0] clear_streak_next;
    logic [SEQ_W-1:0]    last_seq_next;
    sssr_res_t           res_next;

    logic                fire;
    logic                is_eval;
    logic                len_nz;
    logic [POS_W:0]      diff;
    logic [POS_W:0]      wrapped;
    logic [POS_W-1:0]    driven;
    logic                guard;
    logic [POS_W:0]      pass_thresh;
    logic                passed;
    logic                behind;
    logic [SPD_W:0]      spd_abs;
    logic                stopped;
    logic                fresh;
    logic                evidence;
    logic [CONF_W-1:0]   need;
    logic                cb;
    logic                cc;

    function automatic logic [STREAK_W-1:0] bump(input logic [STREAK_W-1:0] v);
        bump = (v == {STREAK_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    assign is_eval  = (in_item.req.op == OP_EVAL);
    assign in_ready = !is_eval || !out_valid_reg || res.ready;
    assign fire     = in_valid && in_ready;

    assign len_nz      = |cfg.track_length;
    assign diff        = {1'b0, in_item.rem} - {1'b0, start_mod};
    assign wrapped     = diff[POS_W] ? (diff + {1'b0, cfg.track_length}) : diff;
    assign driven      = wrapped[POS_W-1:0];
    assign guard       = len_nz && ({driven, 1'b0} < {1'b0, cfg.track_length});
    assign pass_thresh = {1'b0, danger_reg} + (POS_W + 1)'(cfg.pass_margin);
    assign passed      = guard && ({1'b0, driven} >= pass_thresh);
    assign behind      = guard && (driven >= danger_reg);

    assign spd_abs = in_item.req.speed[SPD_W-1]
                   ? ((SPD_W + 1)'(1) << SPD_W) - {1'b0, in_item.req.speed}
                   : {1'b0, in_item.req.speed};
    assign stopped = spd_abs <= (SPD_W + 1)'(cfg.stopped_speed_limit);

    assign fresh    = in_item.req.frame_seq > start_seq_reg;
    assign evidence = in_item.req.frame_empty ? (behind && fresh) : in_item.req.corridor_clear;
    assign need     = (cfg.confirm_cycles == '0) ? CONF_W'(1) : cfg.confirm_cycles;

    always_comb
    begin
        avoid_streak_next = in_item.req.avoid_valid ? bump(avoid_streak_reg) : '0;
        clear_streak_next = clear_streak_reg;
        last_seq_next     = last_seq_reg;
        if (stopped && evidence)
        begin
            if (in_item.req.frame_seq != last_seq_reg)
            begin
                clear_streak_next = bump(clear_streak_reg);
                last_seq_next     = in_item.req.frame_seq;
            end
        end
        else
        begin
            clear_streak_next = '0;
            last_seq_next     = '0;
        end
    end

    assign cb = (avoid_streak_next >= STREAK_W'(need)) && in_item.req.can_select_avoid;
    assign cc = clear_streak_next >= STREAK_W'(need);

    always_comb
    begin
        res_next = '0;
        if (!latch_reg)
        begin
            res_next.handoff_ok = 1'b1;
        end
        else
        begin
            res_next.latched          = 1'b1;
            res_next.passed_flag      = passed;
            res_next.stopped_flag     = stopped;
            res_next.cond_b           = cb;
            res_next.cond_c           = cc;
            res_next.avoid_streak_out = avoid_streak_next;
            res_next.clear_streak_out = clear_streak_next;
            priority if (passed)
            begin
                res_next.release_ok  = 1'b1;
                res_next.release_why = WHY_PASSED;
                res_next.handoff_ok  = 1'b1;
            end
            else if (cb)
            begin
                res_next.release_ok  = 1'b1;
                res_next.release_why = WHY_AVOID;
            end
            else if (cc)
            begin
                res_next.release_ok  = 1'b1;
                res_next.release_why = WHY_CLEAR;
                res_next.handoff_ok  = 1'b1;
            end
            else
            begin
                res_next.release_why = WHY_NONE;
            end
        end
    end

    assign start_load.load  = fire && ((in_item.req.op == OP_ACTIVATE) ||
                                       (in_item.req.op == OP_RESET));
    assign start_load.value = (in_item.req.op == OP_ACTIVATE) ? in_item.rem : '0;
    assign start_pos        = start_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg        <= 1'b0;
            start_pos_reg    <= '0;
            danger_reg       <= '0;
            start_seq_reg    <= '0;
            avoid_streak_reg <= '0;
            clear_streak_reg <= '0;
            last_seq_reg     <= '0;
        end
        else if (fire)
        begin
            unique case (in_item.req.op)
                OP_ACTIVATE:
                begin
                    latch_reg        <= 1'b1;
                    start_pos_reg    <= in_item.req.position;
                    danger_reg       <= in_item.req.danger_end;
                    start_seq_reg    <= in_item.req.frame_seq;
                    avoid_streak_reg <= '0;
                    clear_streak_reg <= '0;
                    last_seq_reg     <= '0;
                end
                OP_RESET:
                begin
                    latch_reg        <= 1'b0;
                    start_pos_reg    <= '0;
                    danger_reg       <= '0;
                    start_seq_reg    <= '0;
                    avoid_streak_reg <= '0;
                    clear_streak_reg <= '0;
                    last_seq_reg     <= '0;
                end
                OP_EVAL:
                begin
                    if (latch_reg)
                    begin
                        avoid_streak_reg <= avoid_streak_next;
                        clear_streak_reg <= clear_streak_next;
                        last_seq_reg     <= last_seq_next;
                    end
                end
                OP_NONE:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && is_eval)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && is_eval)
        begin
            out_reg <= res_next;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    `SSSR_ASSERT_NEVER(a_release_unlatched, out_valid_reg && out_reg.release_ok && !out_reg.latched, "release without latch")
    `SSSR_ASSERT(a_why_matches_ok, out_valid_reg |-> ((out_reg.release_why != WHY_NONE) == out_reg.release_ok), "release reason mismatch")
    `SSSR_ASSERT(a_reset_clears, fire && (in_item.req.op == OP_RESET) |=> !latch_reg && (avoid_streak_reg == '0) && (clear_streak_reg == '0), "reset request left latch state")
    `SSSR_ASSERT(a_clear_step, (clear_streak_reg != $past(clear_streak_reg)) |-> ((clear_streak_reg == '0) || (clear_streak_reg == $past(clear_streak_reg) + 1'b1)), "clear streak jumped")

endmodule

// File: test/tb_safe_stop_release_supervisor_top.sv
// Testbench for the safe stop release supervisor: directed rows and random phases.
`timescale 1ns / 1ps

module tb_safe_stop_release_supervisor_top import sssr_pkg::*; ();

    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLDOFF_LEN   = 400;
    localparam int SETTLE_CYCLES = 30;
    localparam int TAIL_CYCLES   = 40;
    localparam int PHASE_ITEMS   = 180;

    localparam sssr_res_t UNLATCHED_VERDICT = '{
        latched: 1'b0, release_ok: 1'b0, release_why: WHY_NONE, handoff_ok: 1'b1,
        passed_flag: 1'b0, stopped_flag: 1'b0, cond_b: 1'b0, cond_c: 1'b0,
        avoid_streak_out: '0, clear_streak_out: '0};
    localparam sssr_res_t FIRST_AVOID_VERDICT = '{
        latched: 1'b1, release_ok: 1'b1, release_why: WHY_AVOID, handoff_ok: 1'b0,
        passed_flag: 1'b0, stopped_flag: 1'b0, cond_b: 1'b1, cond_c: 1'b0,
        avoid_streak_out: 16'd1, clear_streak_out: '0};

    typedef enum bit {ROW_CONFIG, ROW_REQUEST} row_kind_e;

    typedef struct {
        row_kind_e kind;
        sssr_cfg_t cfg;
        sssr_req_t req;
        bit        typed;
        bit        typed_has;
        sssr_res_t typed_want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sssr_req_if req_if ();
    sssr_res_if res_if ();
    sssr_cfg_if cfg_if ();

    safe_stop_release_supervisor_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    logic [POS_W-1:0]    cfg_track   = '0;
    logic [MARGIN_W-1:0] cfg_margin  = '0;
    logic [LIM_W-1:0]    cfg_limit   = '0;
    logic [CONF_W-1:0]   cfg_confirm = 8'd1;

    bit                  model_latched;
    logic [POS_W-1:0]    model_origin;
    logic [POS_W-1:0]    model_danger;
    logic [SEQ_W-1:0]    model_start_seq;
    logic [STREAK_W-1:0] model_avoid_run;
    logic [STREAK_W-1:0] model_clear_run;
    logic [SEQ_W-1:0]    model_last_seq;

    sssr_res_t awaited_verdicts[$];
    sssr_res_t verdict_head;
    stim_row_t directed_rows[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    bit no_idle        = 1'b0;
    int holdoff_asked  = 0;
    int holdoff_served = 0;
    int holdoff_left   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [STREAK_W-1:0] bump_streak(input logic [STREAK_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void clear_latch_model();
        model_latched   = 1'b0;
        model_origin    = '0;
        model_danger    = '0;
        model_start_seq = '0;
        model_avoid_run = '0;
        model_clear_run = '0;
        model_last_seq  = '0;
    endfunction

    function automatic bit predict_release(input sssr_req_t r, output sssr_res_t v);
        longint              diff;
        longint              driven;
        bit                  guard;
        bit                  passed;
        bit                  stopped;
        bit                  behind;
        bit                  evidence;
        bit                  cb;
        bit                  cc;
        int unsigned         spd_abs;
        logic [STREAK_W-1:0] need;
        v = '0;
        if (r.op == OP_ACTIVATE)
        begin
            model_latched   = 1'b1;
            model_origin    = r.position;
            model_danger    = r.danger_end;
            model_start_seq = r.frame_seq;
            model_avoid_run = '0;
            model_clear_run = '0;
            model_last_seq  = '0;
            return 1'b0;
        end
        if (r.op == OP_RESET)
        begin
            clear_latch_model();
            return 1'b0;
        end
        if (r.op != OP_EVAL)
            return 1'b0;
        if (!model_latched)
        begin
            v.handoff_ok = 1'b1;
            return 1'b1;
        end
        guard  = 1'b0;
        driven = 0;
        if (cfg_track != '0)
        begin
            diff   = longint'(r.position) - longint'(model_origin);
            driven = diff % longint'(cfg_track);
            if (driven < 0)
                driven = driven + longint'(cfg_track);
            guard = (2 * driven) < longint'(cfg_track);
        end
        passed  = guard && (driven >= longint'(model_danger) + longint'(cfg_margin));
        spd_abs = r.speed[SPD_W-1] ? (32'h10000 - {16'd0, r.speed}) : {16'd0, r.speed};
        stopped = spd_abs <= cfg_limit;
        model_avoid_run = r.avoid_valid ? bump_streak(model_avoid_run) : '0;
        behind   = guard && (driven >= longint'(model_danger));
        evidence = r.frame_empty ? (behind && (r.frame_seq > model_start_seq))
                                 : r.corridor_clear;
        if (stopped && evidence)
        begin
            if (r.frame_seq != model_last_seq)
            begin
                model_clear_run = bump_streak(model_clear_run);
                model_last_seq  = r.frame_seq;
            end
        end
        else
        begin
            model_clear_run = '0;
            model_last_seq  = '0;
        end
        need = (cfg_confirm == '0) ? 16'd1 : {8'd0, cfg_confirm};
        cb   = (model_avoid_run >= need) && r.can_select_avoid;
        cc   = model_clear_run >= need;
        v.latched = 1'b1;
        if (passed)
        begin
            v.release_ok  = 1'b1;
            v.release_why = WHY_PASSED;
            v.handoff_ok  = 1'b1;
        end
        else if (cb)
        begin
            v.release_ok  = 1'b1;
            v.release_why = WHY_AVOID;
        end
        else if (cc)
        begin
            v.release_ok  = 1'b1;
            v.release_why = WHY_CLEAR;
            v.handoff_ok  = 1'b1;
        end
        v.passed_flag      = passed;
        v.stopped_flag     = stopped;
        v.cond_b           = cb;
        v.cond_c           = cc;
        v.avoid_streak_out = model_avoid_run;
        v.clear_streak_out = model_clear_run;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 50)
            $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
    endtask

    task automatic send_request(input sssr_req_t r, input bit use_typed = 1'b0,
                                input bit typed_has = 1'b0, input sssr_res_t typed_want = '0);
        sssr_res_t predicted;
        bit        has_result;
        while (!no_idle && $urandom_range(99) < 24)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge clk); while (!req_if.ready);
        has_result = predict_release(r, predicted);
        if (use_typed)
        begin
            if (typed_has)
                awaited_verdicts.push_back(typed_want);
        end
        else if (has_result)
            awaited_verdicts.push_back(predicted);
    endtask

    task automatic settle_block();
        req_if.valid <= 1'b0;
        while (awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input sssr_cfg_t c);
        logic [CFG_IDX_W-1:0]  idx_list [4];
        logic [CFG_DATA_W-1:0] val_list [4];
        idx_list = '{CFG_TRACK_LENGTH, CFG_PASS_MARGIN, CFG_STOP_LIMIT, CFG_CONFIRM};
        val_list = '{32'(c.track_length), 32'(c.pass_margin),
                     32'(c.stopped_speed_limit), 32'(c.confirm_cycles)};
        for (int i = 0; i < 4; i++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.data  <= '{index: idx_list[i], value: val_list[i]};
            do @(posedge clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
        cfg_track   = c.track_length;
        cfg_margin  = c.pass_margin;
        cfg_limit   = c.stopped_speed_limit;
        cfg_confirm = c.confirm_cycles;
    endtask

    function automatic stim_row_t request_row(input logic [1:0] op, input logic [19:0] pos,
                                              input logic [19:0] dend, input int speed,
                                              input logic [31:0] seq, input bit av,
                                              input bit fe, input bit cc, input bit cs);
        stim_row_t row;
        row                      = '{kind: ROW_REQUEST, default: '0};
        row.req.op               = op;
        row.req.position         = pos;
        row.req.danger_end       = dend;
        row.req.speed            = 16'(speed);
        row.req.frame_seq        = seq;
        row.req.avoid_valid      = av;
        row.req.frame_empty      = fe;
        row.req.corridor_clear   = cc;
        row.req.can_select_avoid = cs;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input stim_row_t row, input bit has,
                                            input sssr_res_t want);
        row.typed      = 1'b1;
        row.typed_has  = has;
        row.typed_want = want;
        return row;
    endfunction

    function automatic stim_row_t config_row(input logic [19:0] track, input logic [15:0] margin,
                                             input logic [14:0] limit, input logic [7:0] confirm);
        stim_row_t row;
        row                         = '{kind: ROW_CONFIG, default: '0};
        row.cfg.track_length        = track;
        row.cfg.pass_margin         = margin;
        row.cfg.stopped_speed_limit = limit;
        row.cfg.confirm_cycles      = confirm;
        return row;
    endfunction

    task automatic run_random_phase(input int budget, input bit with_holdoff);
        int               sent;
        int               run_len;
        longint           lap;
        longint           driven;
        logic [POS_W-1:0] origin;
        logic [SEQ_W-1:0] seq;
        int unsigned      mag;
        bit               neg;
        bit               holdoff_done;
        sssr_req_t        r;
        sent         = 0;
        holdoff_done = 1'b0;
        lap          = longint'(cfg_track);
        while (sent < budget)
        begin
            if (with_holdoff && !holdoff_done && sent >= budget / 4)
            begin
                holdoff_asked++;
                holdoff_done = 1'b1;
            end
            if ($urandom_range(99) < 10)
            begin
                r.op               = 2'($urandom_range(3));
                r.position         = 20'($urandom);
                r.danger_end       = 20'($urandom);
                r.speed            = 16'($urandom);
                r.frame_seq        = $urandom;
                r.avoid_valid      = 1'($urandom);
                r.frame_empty      = 1'($urandom);
                r.corridor_clear   = 1'($urandom);
                r.can_select_avoid = 1'($urandom);
                send_request(r);
                if (r.op != OP_NONE)
                    sent++;
            end
            else
            begin
                if (lap > 0 && $urandom_range(9) != 0)
                    origin = 20'($urandom_range(int'(lap - 1)));
                else
                    origin = 20'($urandom);
                case ($urandom_range(3))
                    0: seq = $urandom_range(3);
                    1: seq = 32'hFFFF_FFFF - $urandom_range(40);
                    default: seq = $urandom;
                endcase
                r             = '0;
                r.op          = OP_ACTIVATE;
                r.position    = origin;
                r.danger_end  = (lap > 1 && $urandom_range(9) != 0)
                                ? 20'($urandom_range(int'(lap / 3))) : 20'($urandom);
                r.speed       = 16'($urandom);
                r.frame_seq   = seq;
                send_request(r);
                sent++;
                run_len = $urandom_range(30, 1);
                driven  = 0;
                for (int k = 0; k < run_len && sent < budget; k++)
                begin
                    r.op       = ($urandom_range(99) < 4) ? OP_RESET : OP_EVAL;
                    if (lap > 0)
                    begin
                        driven     = driven + $urandom_range(int'(lap / 12 + 1));
                        r.position = 20'((longint'(origin) + driven) % lap);
                    end
                    if (lap == 0 || $urandom_range(19) == 0)
                        r.position = 20'($urandom);
                    mag = $urandom_range(int'(cfg_limit) + 4);
                    if ($urandom_range(9) == 0)
                        mag = $urandom_range(32768);
                    neg = 1'($urandom);
                    if (mag >= 32768)
                    begin
                        mag = 32768;
                        neg = 1'b1;
                    end
                    r.speed = neg ? (16'd0 - 16'(mag)) : 16'(mag);
                    if ($urandom_range(9) == 0)
                        seq = $urandom;
                    else
                        seq = seq + $urandom_range(2);
                    r.frame_seq        = seq;
                    r.danger_end       = 20'($urandom);
                    r.avoid_valid      = $urandom_range(99) < 70;
                    r.frame_empty      = 1'($urandom);
                    r.corridor_clear   = $urandom_range(99) < 60;
                    r.can_select_avoid = $urandom_range(99) < 70;
                    send_request(r);
                    sent++;
                end
            end
        end
    endtask

    // result side: ready with random stalls, and long hold-offs on request
    always @(posedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (holdoff_left > 0)
        begin
            holdoff_left = holdoff_left - 1;
            res_if.ready <= 1'b0;
        end
        else if (holdoff_asked != holdoff_served)
        begin
            holdoff_served = holdoff_asked;
            holdoff_left   = HOLDOFF_LEN;
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= no_idle || ($urandom_range(99) >= 24);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (awaited_verdicts.size() == 0)
                    report_mismatch("result with no evaluate request waiting");
                else
                begin
                    verdict_head = awaited_verdicts.pop_front();
                    check_field("latched", 16'(res_if.data.latched), 16'(verdict_head.latched));
                    check_field("release_ok", 16'(res_if.data.release_ok),
                                16'(verdict_head.release_ok));
                    check_field("release_why", 16'(res_if.data.release_why),
                                16'(verdict_head.release_why));
                    check_field("handoff_ok", 16'(res_if.data.handoff_ok),
                                16'(verdict_head.handoff_ok));
                    check_field("passed_flag", 16'(res_if.data.passed_flag),
                                16'(verdict_head.passed_flag));
                    check_field("stopped_flag", 16'(res_if.data.stopped_flag),
                                16'(verdict_head.stopped_flag));
                    check_field("cond_b", 16'(res_if.data.cond_b), 16'(verdict_head.cond_b));
                    check_field("cond_c", 16'(res_if.data.cond_c), 16'(verdict_head.cond_c));
                    check_field("avoid_streak_out", res_if.data.avoid_streak_out,
                                verdict_head.avoid_streak_out);
                    check_field("clear_streak_out", res_if.data.clear_streak_out,
                                verdict_head.clear_streak_out);
                end
            end
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        sssr_cfg_t   c;
        int unsigned margin_cap;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        rst_n        = 1'b0;
        clear_latch_model();

        directed_rows.push_back(typed_row(request_row(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0),
                                          1'b1, UNLATCHED_VERDICT));
        directed_rows.push_back(typed_row(request_row(OP_NONE, 20'hFFFFF, 20'hFFFFF, -1,
                                                      32'hFFFF_FFFF, 1, 1, 1, 1),
                                          1'b0, '0));
        directed_rows.push_back(request_row(OP_ACTIVATE, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(request_row(OP_EVAL, 0, 0, 0, 5, 0, 1, 0, 0));
        directed_rows.push_back(typed_row(request_row(OP_EVAL, 0, 0, -32768, 6, 1, 0, 0, 1),
                                          1'b1, FIRST_AVOID_VERDICT));
        directed_rows.push_back(request_row(OP_RESET, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(typed_row(request_row(OP_EVAL, 20'hFFFFF, 0, 32767, 9,
                                                      1, 1, 1, 1),
                                          1'b1, UNLATCHED_VERDICT));
        directed_rows.push_back(config_row(20'hFFFFF, 16'hFFFF, 15'h7FFF, 8'hFF));
        directed_rows.push_back(request_row(OP_ACTIVATE, 20'hFFFFF, 0, 0, 32'hFFFF_FFFF,
                                            0, 0, 0, 0));
        directed_rows.push_back(request_row(OP_EVAL, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, 1, 1));
        directed_rows.push_back(request_row(OP_EVAL, 100000, 0, 32767, 0, 0, 1, 0, 0));
        directed_rows.push_back(request_row(OP_EVAL, 70000, 0, -32767, 3, 0, 0, 1, 0));
        directed_rows.push_back(request_row(OP_EVAL, 600000, 0, -32768, 4, 0, 0, 1, 0));
        directed_rows.push_back(config_row(20'd1000, 16'd10, 15'd50, 8'd0));
        directed_rows.push_back(request_row(OP_ACTIVATE, 20'hFFFFF, 100, 0, 10, 0, 0, 0, 0));
        directed_rows.push_back(request_row(OP_EVAL, 200, 0, 50, 11, 0, 1, 0, 0));
        directed_rows.push_back(request_row(OP_EVAL, 0, 0, -50, 0, 0, 0, 1, 0));
        directed_rows.push_back(request_row(OP_EVAL, 0, 0, 0, 7, 0, 0, 1, 0));
        directed_rows.push_back(request_row(OP_EVAL, 0, 0, 0, 7, 0, 0, 1, 0));
        directed_rows.push_back(request_row(OP_EVAL, 0, 0, 51, 8, 0, 0, 1, 0));
        directed_rows.push_back(request_row(OP_EVAL, 0, 0, 0, 8, 1, 0, 0, 0));
        directed_rows.push_back(request_row(OP_EVAL, 0, 0, 0, 9, 1, 0, 1, 1));
        directed_rows.push_back(request_row(OP_EVAL, 695, 0, 0, 12, 0, 1, 0, 0));
        directed_rows.push_back(request_row(OP_ACTIVATE, 5, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(request_row(OP_EVAL, 5, 0, 0, 0, 0, 1, 0, 0));
        directed_rows.push_back(config_row(20'd1, 16'd0, 15'd0, 8'd1));
        directed_rows.push_back(request_row(OP_ACTIVATE, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(request_row(OP_EVAL, 1, 0, 1, 1, 0, 1, 0, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
            begin
                settle_block();
                load_config(directed_rows[i].cfg);
            end
            else
                send_request(directed_rows[i].req, directed_rows[i].typed,
                             directed_rows[i].typed_has, directed_rows[i].typed_want);
        end

        for (int p = 0; p < 8; p++)
        begin
            settle_block();
            if (p == 0)
                c = '{track_length: 20'hFFFFF, pass_margin: 16'hFFFF,
                      stopped_speed_limit: 15'h7FFF, confirm_cycles: 8'hFF};
            else if (p == 1)
                c = '{track_length: '0, pass_margin: '0, stopped_speed_limit: '0,
                      confirm_cycles: '0};
            else
            begin
                case ($urandom_range(3))
                    0: c.track_length = 20'($urandom_range(64, 2));
                    1: c.track_length = 20'($urandom_range(5000, 65));
                    2: c.track_length = 20'($urandom_range(200000, 5000));
                    default: c.track_length = 20'($urandom);
                endcase
                margin_cap = c.track_length / 8;
                if (margin_cap > 65535)
                    margin_cap = 65535;
                c.pass_margin = (c.track_length > 8) ? 16'($urandom_range(margin_cap))
                                                     : 16'($urandom_range(3));
                c.stopped_speed_limit = ($urandom_range(3) == 0) ? 15'($urandom)
                                                                 : 15'($urandom_range(200));
                c.confirm_cycles = ($urandom_range(7) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(5));
            end
            load_config(c);
            no_idle = (p == 3);
            run_random_phase(PHASE_ITEMS, p == 5);
        end

        req_if.valid <= 1'b0;
        while (awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/sssr_pkg.sv
src/sssr_if.sv
src/sssr_cfg_regs.sv
src/sssr_mod_pipe.sv
src/sssr_remod.sv
src/sssr_core.sv
src/safe_stop_release_supervisor_top.sv
test/tb_safe_stop_release_supervisor_top.sv
